### rtl/snfcs_pkg.sv
// Package for the SPI NOR flash command sequencer.
// Holds the transaction structs, command/operation codes, flash opcodes and phase codes.
// No dependencies.
`timescale 1ns / 1ps

package snfcs_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // input commands
    localparam logic [1:0] CMD_START     = 2'd0;
    localparam logic [1:0] CMD_PROG_DATA = 2'd1;
    localparam logic [1:0] CMD_REPLY     = 2'd2;

    // host operations
    localparam logic [3:0] OP_READ_ID      = 4'd0;
    localparam logic [3:0] OP_READ_STATUS  = 4'd1;
    localparam logic [3:0] OP_WRITE_EN     = 4'd2;
    localparam logic [3:0] OP_WRITE_DIS    = 4'd3;
    localparam logic [3:0] OP_READ_DATA    = 4'd4;
    localparam logic [3:0] OP_PAGE_PROGRAM = 4'd5;
    localparam logic [3:0] OP_SECTOR_ERASE = 4'd6;
    localparam logic [3:0] OP_BLOCK_ERASE  = 4'd7;
    localparam logic [3:0] OP_CHIP_ERASE   = 4'd8;

    // flash opcodes
    localparam logic [7:0] FL_WREN   = 8'h06;
    localparam logic [7:0] FL_WRDI   = 8'h04;
    localparam logic [7:0] FL_RDSR   = 8'h05;
    localparam logic [7:0] FL_READ   = 8'h03;
    localparam logic [7:0] FL_PP     = 8'h02;
    localparam logic [7:0] FL_SE     = 8'h20;
    localparam logic [7:0] FL_BE     = 8'hD8;
    localparam logic [7:0] FL_CE     = 8'hC7;
    localparam logic [7:0] FL_RDID   = 8'h9F;
    localparam logic [7:0] FL_DUMMY  = 8'hFF;

    localparam int STATUS_BUSY_BIT = 0;
    localparam logic [15:0] ID_BYTES = 16'd3;

    // sequencer phases
    localparam logic [1:0] PH_IDLE         = 2'd0;
    localparam logic [1:0] PH_READING      = 2'd1;
    localparam logic [1:0] PH_PROGRAM_DATA = 2'd2;
    localparam logic [1:0] PH_POLLING      = 2'd3;

    typedef struct packed {
        logic [1:0]           command;
        logic [3:0]           operation;
        logic [ADDR_BITS-1:0] address;
        logic [15:0]          length;
        logic [7:0]           write_byte;
        logic [7:0]           reply_byte;
    } item_in_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] mosi_byte;
        logic       frame_end;
        logic       expect_reply;
        logic       data_valid;
        logic [7:0] read_byte;
        logic       op_done;
        logic       op_rejected;
        logic       last;
    } item_out_t;

    // decoder result: burst of results plus the state update
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        item_out_t [MAX_RESULTS-1:0]       list;
        logic                              upd;
        logic [1:0]                        phase;
        logic [15:0]                       bytes_left;
    } dec_t;

endpackage

### rtl/snfcs_decode.sv
// Item decoder: builds the result burst and next state for one transaction.
// Depends on snfcs_pkg.
`timescale 1ns / 1ps

module snfcs_decode #(
    parameter int PAGE_BYTES = 256
) (
    input  snfcs_pkg::item_in_t item,
    input  logic [1:0]          phase,
    input  logic [15:0]         bytes_left,
    output snfcs_pkg::dec_t     dec
);

    function automatic snfcs_pkg::item_out_t mk(
        input logic       send,
        input logic [7:0] mosi,
        input logic       fe,
        input logic       er,
        input logic       dv,
        input logic [7:0] rb,
        input logic       done,
        input logic       rej
    );
        snfcs_pkg::item_out_t r;
        r.send_valid   = send;
        r.mosi_byte    = mosi;
        r.frame_end    = fe;
        r.expect_reply = er;
        r.data_valid   = dv;
        r.read_byte    = rb;
        r.op_done      = done;
        r.op_rejected  = rej;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic snfcs_pkg::item_out_t snd(input logic [7:0] b, input logic fe);
        return mk(1'b1, b, fe, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
    endfunction

    function automatic snfcs_pkg::item_out_t dummy(input logic fe);
        return mk(1'b1, snfcs_pkg::FL_DUMMY, fe, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0);
    endfunction

    logic [7:0]  a_hi;
    logic [7:0]  a_mid;
    logic [7:0]  a_lo;
    logic        len_zero;
    logic [15:0] bl_dec;

    assign a_hi     = item.address[snfcs_pkg::ADDR_BITS-1 -: 8];
    assign a_mid    = item.address[snfcs_pkg::ADDR_BITS-9 -: 8];
    assign a_lo     = item.address[7:0];
    assign len_zero = (item.length == 16'd0);
    assign bl_dec   = bytes_left - 16'd1;

    always_comb
    begin
        dec.count      = '0;
        dec.upd        = 1'b0;
        dec.phase      = phase;
        dec.bytes_left = bytes_left;
        for (int i = 0; i < snfcs_pkg::MAX_RESULTS; i++)
        begin
            dec.list[i] = '0;
        end

        if (phase == snfcs_pkg::PH_IDLE && item.command == snfcs_pkg::CMD_START)
        begin
            case (item.operation)
                snfcs_pkg::OP_READ_ID:
                begin
                    dec.upd        = 1'b1;
                    dec.count      = snfcs_pkg::CNT_W'(2);
                    dec.list[0]    = snd(snfcs_pkg::FL_RDID, 1'b0);
                    dec.list[1]    = dummy(1'b0);
                    dec.bytes_left = snfcs_pkg::ID_BYTES;
                    dec.phase      = snfcs_pkg::PH_READING;
                end
                snfcs_pkg::OP_READ_STATUS:
                begin
                    dec.upd        = 1'b1;
                    dec.count      = snfcs_pkg::CNT_W'(2);
                    dec.list[0]    = snd(snfcs_pkg::FL_RDSR, 1'b0);
                    dec.list[1]    = dummy(1'b1);
                    dec.bytes_left = 16'd1;
                    dec.phase      = snfcs_pkg::PH_READING;
                end
                snfcs_pkg::OP_WRITE_EN, snfcs_pkg::OP_WRITE_DIS:
                begin
                    dec.upd     = 1'b1;
                    dec.count   = snfcs_pkg::CNT_W'(1);
                    dec.list[0] = mk(1'b1,
                        (item.operation == snfcs_pkg::OP_WRITE_EN) ?
                            snfcs_pkg::FL_WREN : snfcs_pkg::FL_WRDI,
                        1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
                end
                snfcs_pkg::OP_READ_DATA:
                begin
                    dec.upd     = 1'b1;
                    dec.list[0] = snd(snfcs_pkg::FL_READ, 1'b0);
                    dec.list[1] = snd(a_hi, 1'b0);
                    dec.list[2] = snd(a_mid, 1'b0);
                    dec.list[3] = mk(1'b1, a_lo, len_zero, 1'b0, 1'b0, 8'd0,
                                     len_zero, 1'b0);
                    if (len_zero)
                    begin
                        dec.count = snfcs_pkg::CNT_W'(4);
                    end
                    else
                    begin
                        dec.count      = snfcs_pkg::CNT_W'(5);
                        dec.list[4]    = dummy(item.length == 16'd1);
                        dec.bytes_left = item.length;
                        dec.phase      = snfcs_pkg::PH_READING;
                    end
                end
                snfcs_pkg::OP_PAGE_PROGRAM:
                begin
                    dec.upd = 1'b1;
                    if (len_zero || item.length > 16'(PAGE_BYTES))
                    begin
                        dec.count   = snfcs_pkg::CNT_W'(1);
                        dec.list[0] = mk(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0,
                                         1'b0, 1'b1);
                    end
                    else
                    begin
                        dec.count      = snfcs_pkg::CNT_W'(5);
                        dec.list[0]    = snd(snfcs_pkg::FL_WREN, 1'b1);
                        dec.list[1]    = snd(snfcs_pkg::FL_PP, 1'b0);
                        dec.list[2]    = snd(a_hi, 1'b0);
                        dec.list[3]    = snd(a_mid, 1'b0);
                        dec.list[4]    = snd(a_lo, 1'b0);
                        dec.bytes_left = item.length;
                        dec.phase      = snfcs_pkg::PH_PROGRAM_DATA;
                    end
                end
                snfcs_pkg::OP_SECTOR_ERASE, snfcs_pkg::OP_BLOCK_ERASE:
                begin
                    dec.upd     = 1'b1;
                    dec.count   = snfcs_pkg::CNT_W'(7);
                    dec.list[0] = snd(snfcs_pkg::FL_WREN, 1'b1);
                    dec.list[1] = snd((item.operation == snfcs_pkg::OP_SECTOR_ERASE) ?
                                      snfcs_pkg::FL_SE : snfcs_pkg::FL_BE, 1'b0);
                    dec.list[2] = snd(a_hi, 1'b0);
                    dec.list[3] = snd(a_mid, 1'b0);
                    dec.list[4] = snd(a_lo, 1'b1);
                    dec.list[5] = snd(snfcs_pkg::FL_RDSR, 1'b0);
                    dec.list[6] = dummy(1'b1);
                    dec.phase   = snfcs_pkg::PH_POLLING;
                end
                snfcs_pkg::OP_CHIP_ERASE:
                begin
                    dec.upd     = 1'b1;
                    dec.count   = snfcs_pkg::CNT_W'(4);
                    dec.list[0] = snd(snfcs_pkg::FL_WREN, 1'b1);
                    dec.list[1] = snd(snfcs_pkg::FL_CE, 1'b1);
                    dec.list[2] = snd(snfcs_pkg::FL_RDSR, 1'b0);
                    dec.list[3] = dummy(1'b1);
                    dec.phase   = snfcs_pkg::PH_POLLING;
                end
                default:
                begin
                    dec.upd = 1'b0;
                end
            endcase
        end
        else if (phase == snfcs_pkg::PH_READING && item.command == snfcs_pkg::CMD_REPLY)
        begin
            dec.upd = 1'b1;
            if (bytes_left <= 16'd1)
            begin
                dec.count      = snfcs_pkg::CNT_W'(1);
                dec.list[0]    = mk(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, item.reply_byte,
                                    1'b1, 1'b0);
                dec.bytes_left = 16'd0;
                dec.phase      = snfcs_pkg::PH_IDLE;
            end
            else
            begin
                dec.count      = snfcs_pkg::CNT_W'(2);
                dec.list[0]    = mk(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, item.reply_byte,
                                    1'b0, 1'b0);
                dec.list[1]    = dummy(bl_dec == 16'd1);
                dec.bytes_left = bl_dec;
            end
        end
        else if (phase == snfcs_pkg::PH_PROGRAM_DATA &&
                 item.command == snfcs_pkg::CMD_PROG_DATA)
        begin
            dec.upd = 1'b1;
            if (bytes_left <= 16'd1)
            begin
                dec.count      = snfcs_pkg::CNT_W'(3);
                dec.list[0]    = snd(item.write_byte, 1'b1);
                dec.list[1]    = snd(snfcs_pkg::FL_RDSR, 1'b0);
                dec.list[2]    = dummy(1'b1);
                dec.bytes_left = 16'd0;
                dec.phase      = snfcs_pkg::PH_POLLING;
            end
            else
            begin
                dec.count      = snfcs_pkg::CNT_W'(1);
                dec.list[0]    = snd(item.write_byte, 1'b0);
                dec.bytes_left = bl_dec;
            end
        end
        else if (phase == snfcs_pkg::PH_POLLING && item.command == snfcs_pkg::CMD_REPLY)
        begin
            dec.upd = 1'b1;
            if (item.reply_byte[snfcs_pkg::STATUS_BUSY_BIT])
            begin
                dec.count   = snfcs_pkg::CNT_W'(2);
                dec.list[0] = snd(snfcs_pkg::FL_RDSR, 1'b0);
                dec.list[1] = dummy(1'b1);
            end
            else
            begin
                dec.count   = snfcs_pkg::CNT_W'(1);
                dec.list[0] = mk(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0);
                dec.phase   = snfcs_pkg::PH_IDLE;
            end
        end

        // tag the final result of the burst
        for (int i = 0; i < snfcs_pkg::MAX_RESULTS; i++)
        begin
            dec.list[i].last = (dec.count != '0) &&
                               (snfcs_pkg::CNT_W'(i) == dec.count - snfcs_pkg::CNT_W'(1));
        end
    end

endmodule

### rtl/spi_nor_flash_command_sequencer.sv
// First result is registered and valid the cycle after acceptance; an item yields 0 to 7 results.
// Throughput: one result per cycle while out_ready is high; a new transaction is taken when the
// burst queue is empty or its final entry leaves in the same cycle.
// Items that cause no result are absorbed with no state change.
// Reset (rst_n, async, active low): phase idle, byte counter zero, burst queue empty.
// Depends on snfcs_pkg and snfcs_decode.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  snfcs_pkg::item_in_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output snfcs_pkg::item_out_t  out_item
);

    localparam int N = snfcs_pkg::MAX_RESULTS;
    localparam int CW = snfcs_pkg::CNT_W;

    // sequencer state
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    // burst queue: entry 0 is the result on the output, entries shift down on a take
    snfcs_pkg::item_out_t [N-1:0] q_reg, q_next;
    logic [CW-1:0]                cnt_reg, cnt_next;

    snfcs_pkg::dec_t dec;
    logic            in_fire;
    logic            out_fire;

    // Decode straight from the port against the current state; state
    // updates at the accept edge so the next item sees it.
    snfcs_decode #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_decode (
        .item       (in_item),
        .phase      (phase_reg),
        .bytes_left (bytes_left_reg),
        .dec        (dec)
    );

    assign out_valid = (cnt_reg != '0);
    assign out_item  = q_reg[0];
    assign out_fire  = out_valid && out_ready;

    // Take a new transaction once the queue drains, including the cycle in
    // which its last entry is taken.
    assign in_ready  = (cnt_reg == '0) || (cnt_reg == CW'(1) && out_ready);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;

        if (out_fire)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            cnt_next = cnt_reg - CW'(1);
        end

        if (in_fire && dec.upd)
        begin
            phase_next      = dec.phase;
            bytes_left_next = dec.bytes_left;
        end

        if (in_fire && dec.count != '0)
        begin
            q_next   = dec.list;
            cnt_next = dec.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= snfcs_pkg::PH_IDLE;
            bytes_left_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

`ifndef SYNTHESIS
    // the result at the head carries last exactly when it is the only one queued
    a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last == (cnt_reg == CW'(1))))
        else $error("last flag does not match burst queue depth");

    // counter is clear whenever no data or program transfer is in progress
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == snfcs_pkg::PH_IDLE || phase_reg == snfcs_pkg::PH_POLLING)
        |-> (bytes_left_reg == 16'd0))
        else $error("byte counter nonzero outside read/program");

    // a read or program in progress always has bytes outstanding
    a_busy_count_set: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == snfcs_pkg::PH_READING || phase_reg == snfcs_pkg::PH_PROGRAM_DATA)
        |-> (bytes_left_reg != 16'd0))
        else $error("byte counter empty during read/program");

    // a rejected program leaves the sequencer idle
    a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.op_rejected) |-> (phase_reg == snfcs_pkg::PH_IDLE))
        else $error("rejected program left sequencer busy");
`endif

endmodule

### sim/tb_spi_nor_flash_command_sequencer.sv
// Testbench for spi_nor_flash_command_sequencer: a directed run, then state-aware random traffic.
// A scoreboard class predicts every result; random stalls on both sides. Needs rtl/snfcs_pkg.sv.
`timescale 1ns / 1ps

module tb_spi_nor_flash_command_sequencer;

    localparam int PAGE_SIZE      = 256;
    localparam int ITEM_COUNT     = 410;    // input transactions, directed ones included
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    snfcs_pkg::item_in_t  in_item;
    logic                 out_valid;
    logic                 out_ready;
    snfcs_pkg::item_out_t out_item;

    // Quiet stretches with no idling on either side; the stimulus loop toggles this.
    bit calm;
    int sent_items;     // input transactions accepted so far
    int idle_cycles;
    int out_stall;

    // Predicts the result burst of each accepted transaction and checks the results in order.
    class flash_seq_scoreboard;
        logic [1:0]           phase;
        logic [3:0]           cur_op;
        logic [15:0]          bytes_left;
        snfcs_pkg::item_out_t burst[$];
        snfcs_pkg::item_out_t pending[$];
        int                   errors;

        function new();
            phase      = snfcs_pkg::PH_IDLE;
            cur_op     = '0;
            bytes_left = '0;
            errors     = 0;
        endfunction

        function void emit(logic send, logic [7:0] mosi, logic fe, logic er, logic dv,
                           logic [7:0] rb, logic done, logic rej);
            snfcs_pkg::item_out_t r;
            r.send_valid   = send;
            r.mosi_byte    = mosi;
            r.frame_end    = fe;
            r.expect_reply = er;
            r.data_valid   = dv;
            r.read_byte    = rb;
            r.op_done      = done;
            r.op_rejected  = rej;
            r.last         = 1'b0;
            burst.push_back(r);
        endfunction

        function void send_byte(logic [7:0] b, logic fe);
            emit(1'b1, b, fe, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        endfunction

        // dummy byte whose received value must come back as a reply transaction
        function void send_dummy(logic fe);
            emit(1'b1, snfcs_pkg::FL_DUMMY, fe, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        endfunction

        function void send_addr(logic [23:0] a, logic fe, logic done);
            send_byte(a[23:16], 1'b0);
            send_byte(a[15:8], 1'b0);
            emit(1'b1, a[7:0], fe, 1'b0, 1'b0, 8'h00, done, 1'b0);
        endfunction

        function void start_poll();
            send_byte(snfcs_pkg::FL_RDSR, 1'b0);
            send_dummy(1'b1);
            phase = snfcs_pkg::PH_POLLING;
        endfunction

        // returns the number of results the transaction causes
        function int note_input(snfcs_pkg::item_in_t it);
            burst.delete();
            if (phase == snfcs_pkg::PH_IDLE && it.command == snfcs_pkg::CMD_START)
            begin
                case (it.operation)
                    snfcs_pkg::OP_READ_ID:
                    begin
                        send_byte(snfcs_pkg::FL_RDID, 1'b0);
                        send_dummy(1'b0);
                        bytes_left = snfcs_pkg::ID_BYTES;
                        phase      = snfcs_pkg::PH_READING;
                    end
                    snfcs_pkg::OP_READ_STATUS:
                    begin
                        send_byte(snfcs_pkg::FL_RDSR, 1'b0);
                        send_dummy(1'b1);
                        bytes_left = 16'd1;
                        phase      = snfcs_pkg::PH_READING;
                    end
                    snfcs_pkg::OP_WRITE_EN:
                        emit(1'b1, snfcs_pkg::FL_WREN, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
                    snfcs_pkg::OP_WRITE_DIS:
                        emit(1'b1, snfcs_pkg::FL_WRDI, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
                    snfcs_pkg::OP_READ_DATA:
                    begin
                        send_byte(snfcs_pkg::FL_READ, 1'b0);
                        send_addr(it.address, it.length == 0, it.length == 0);
                        if (it.length != 0)
                        begin
                            send_dummy(it.length == 1);
                            bytes_left = it.length;
                            phase      = snfcs_pkg::PH_READING;
                        end
                    end
                    snfcs_pkg::OP_PAGE_PROGRAM:
                    begin
                        if (it.length == 0 || it.length > PAGE_SIZE)
                            emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
                        else
                        begin
                            send_byte(snfcs_pkg::FL_WREN, 1'b1);
                            send_byte(snfcs_pkg::FL_PP, 1'b0);
                            send_addr(it.address, 1'b0, 1'b0);
                            bytes_left = it.length;
                            phase      = snfcs_pkg::PH_PROGRAM_DATA;
                        end
                    end
                    snfcs_pkg::OP_SECTOR_ERASE, snfcs_pkg::OP_BLOCK_ERASE:
                    begin
                        send_byte(snfcs_pkg::FL_WREN, 1'b1);
                        send_byte((it.operation == snfcs_pkg::OP_SECTOR_ERASE) ?
                                  snfcs_pkg::FL_SE : snfcs_pkg::FL_BE, 1'b0);
                        send_addr(it.address, 1'b1, 1'b0);
                        start_poll();
                    end
                    snfcs_pkg::OP_CHIP_ERASE:
                    begin
                        send_byte(snfcs_pkg::FL_WREN, 1'b1);
                        send_byte(snfcs_pkg::FL_CE, 1'b1);
                        start_poll();
                    end
                    default: ;
                endcase
                if (burst.size() > 0)
                    cur_op = it.operation;
            end
            else if (phase == snfcs_pkg::PH_READING && it.command == snfcs_pkg::CMD_REPLY)
            begin
                if (bytes_left <= 1)
                begin
                    bytes_left = '0;
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, it.reply_byte, 1'b1, 1'b0);
                    phase = snfcs_pkg::PH_IDLE;
                end
                else
                begin
                    bytes_left = bytes_left - 1'b1;
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, it.reply_byte, 1'b0, 1'b0);
                    send_dummy(bytes_left == 1);
                end
            end
            else if (phase == snfcs_pkg::PH_PROGRAM_DATA &&
                     it.command == snfcs_pkg::CMD_PROG_DATA)
            begin
                if (bytes_left <= 1)
                begin
                    bytes_left = '0;
                    send_byte(it.write_byte, 1'b1);
                    start_poll();
                end
                else
                begin
                    bytes_left = bytes_left - 1'b1;
                    send_byte(it.write_byte, 1'b0);
                end
            end
            else if (phase == snfcs_pkg::PH_POLLING && it.command == snfcs_pkg::CMD_REPLY)
            begin
                if (it.reply_byte[snfcs_pkg::STATUS_BUSY_BIT])
                    start_poll();
                else
                begin
                    emit(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
                    phase = snfcs_pkg::PH_IDLE;
                end
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                pending.push_back(burst[i]);
            return burst.size();
        endfunction

        function string fmt(snfcs_pkg::item_out_t r);
            return $sformatf({"send=%0b mosi=%02h fe=%0b er=%0b dv=%0b rd=%02h ",
                              "done=%0b rej=%0b last=%0b"},
                             r.send_valid, r.mosi_byte, r.frame_end, r.expect_reply,
                             r.data_valid, r.read_byte, r.op_done, r.op_rejected, r.last);
        endfunction

        function void check_result(snfcs_pkg::item_out_t got);
            snfcs_pkg::item_out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: %s", $time, fmt(got));
                return;
            end
            want = pending.pop_front();
            if (got.send_valid !== want.send_valid || got.mosi_byte !== want.mosi_byte ||
                got.frame_end !== want.frame_end || got.expect_reply !== want.expect_reply ||
                got.data_valid !== want.data_valid || got.read_byte !== want.read_byte ||
                got.op_done !== want.op_done || got.op_rejected !== want.op_rejected ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch\n  exp %s\n  got %s", $time, fmt(want), fmt(got));
            end
        endfunction
    endclass

    flash_seq_scoreboard sb;

    spi_nor_flash_command_sequencer #(
        .PAGE_BYTES (PAGE_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none during a calm stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic snfcs_pkg::item_in_t mk(logic [1:0] cmd, logic [3:0] op,
                                               logic [23:0] addr, logic [15:0] len,
                                               logic [7:0] wb, logic [7:0] rb);
        snfcs_pkg::item_in_t it;
        it.command    = cmd;
        it.operation  = op;
        it.address    = addr;
        it.length     = len;
        it.write_byte = wb;
        it.reply_byte = rb;
        return it;
    endfunction

    // Next random transaction, shaped by the predicted phase so that most traffic
    // forms complete operations; the rest is fully random noise.
    function automatic snfcs_pkg::item_in_t next_stimulus();
        snfcs_pkg::item_in_t it;
        int                  r;
        int                  q;
        it = mk(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 24'($urandom),
                16'($urandom), 8'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 12)
            return it;
        q = $urandom_range(0, 99);
        case (sb.phase)
            snfcs_pkg::PH_IDLE:
            begin
                it.command   = snfcs_pkg::CMD_START;
                it.operation = 4'($urandom_range(0, 8));
                if (it.operation == snfcs_pkg::OP_READ_DATA)
                begin
                    if (q < 80)
                        it.length = 16'($urandom_range(0, 4));
                    else if (q < 95)
                        it.length = 16'($urandom_range(5, 16));
                    else
                        it.length = 16'($urandom_range(17, 64));
                end
                else if (it.operation == snfcs_pkg::OP_PAGE_PROGRAM)
                begin
                    // full pages are rare: each costs a page of data transactions
                    if (q < 70)
                        it.length = 16'($urandom_range(1, 8));
                    else if (q < 78)
                        it.length = 16'd0;
                    else if (q < 83)
                        it.length = 16'(PAGE_SIZE);
                    else if (q < 90)
                        it.length = 16'($urandom_range(9, 32));
                end
            end
            snfcs_pkg::PH_READING:
                it.command = snfcs_pkg::CMD_REPLY;
            snfcs_pkg::PH_PROGRAM_DATA:
                it.command = snfcs_pkg::CMD_PROG_DATA;
            default:
            begin
                it.command = snfcs_pkg::CMD_REPLY;
                it.reply_byte[snfcs_pkg::STATUS_BUSY_BIT] = 1'($urandom_range(0, 1));
            end
        endcase
        return it;
    endfunction

    // Presents one transaction after a random gap and holds it until accepted.
    task automatic push_item(input snfcs_pkg::item_in_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        void'(sb.note_input(it));
        sent_items++;
    endtask

    // Result side: random stalls, released for whole calm stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    // Watchdog: too many cycles with no transaction on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_spi_nor_flash_command_sequencer: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        out_stall   = 0;
        idle_cycles = 0;
        sent_items  = 0;
        calm        = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every operation, field extremes and the special cases.
        // read ID: three reply transactions, the third closes the operation
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_READ_ID, 24'hFFFFFF, 16'hFFFF,
                     8'hFF, 8'hFF));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'hEF));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h40));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h18));
        // status read, single reply
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_READ_STATUS, 24'h0, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_STATUS, 24'h0, 16'h0,
                     8'h00, 8'h00));
        // one-byte frames finish at once
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_WRITE_EN, 24'h0, 16'h0, 8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_WRITE_DIS, 24'h0, 16'h0, 8'h00, 8'h00));
        // zero-length read: opcode and address only
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_READ_DATA, 24'hFFFFFF, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_READ_DATA, 24'h000000, 16'h1,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_DATA, 24'h0, 16'h0, 8'h00, 8'hFF));
        // program length out of range is rejected, block stays idle
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_PAGE_PROGRAM, 24'h000100, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_PAGE_PROGRAM, 24'h000100, 16'hFFFF,
                     8'h00, 8'h00));
        // program across a page boundary, then busy once before the clear status
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_PAGE_PROGRAM, 24'h0000FF, 16'h2,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_PROG_DATA, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_PROG_DATA, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0,
                     8'hFF, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h01));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'hFE));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_SECTOR_ERASE, 24'hABCDEF, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_BLOCK_ERASE, 24'hFFFFFF, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h00));
        // start while a chip erase polls is ignored
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_CHIP_ERASE, 24'h0, 16'h0,
                     8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_START, snfcs_pkg::OP_WRITE_EN, 24'h0, 16'h0, 8'h00, 8'h00));
        push_item(mk(snfcs_pkg::CMD_REPLY, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h00));
        // undefined operation code and command code are ignored
        push_item(mk(snfcs_pkg::CMD_START, 4'hF, 24'h0, 16'h0, 8'h00, 8'h00));
        push_item(mk(2'd3, snfcs_pkg::OP_READ_ID, 24'h0, 16'h0, 8'h00, 8'h00));

        // Random part; every fourth stretch of 40 runs without idling.
        while (sent_items < ITEM_COUNT)
        begin
            calm = ((sent_items / 40) % 4) == 3;
            push_item(next_stimulus());
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_spi_nor_flash_command_sequencer: done, clean");
        else
            $display("tb_spi_nor_flash_command_sequencer: done, errors");
        $finish;
    end

endmodule
